// ----- design/word_numeronym_abbreviator_defines.svh -----
// assertion macros shared by the word numeronym abbreviator modules
`ifndef WORD_NUMERONYM_ABBREVIATOR_DEFINES_SVH
`define WORD_NUMERONYM_ABBREVIATOR_DEFINES_SVH

// condition holds at every clock edge out of reset
`define WNA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define WNA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define WNA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/wna_pkg.sv -----
// shared types, constants and the delimiter classifier
`timescale 1ns / 1ps

package wna_pkg;

    localparam int CHAR_W      = 8;
    localparam int LENGTH_BITS = 16;
    localparam int MAX_RESULTS = 8;
    localparam int DIGITS      = 5;
    localparam int DIGIT_IDX_W = $clog2(DIGITS + 1);
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam longint unsigned DIGIT_CAP = 64'd100001;
    localparam longint unsigned LEN_FULL  = (64'd1 << LENGTH_BITS) - 64'd1;
    localparam longint unsigned LEN_MAX   = (LEN_FULL > DIGIT_CAP) ? DIGIT_CAP : LEN_FULL;

    typedef logic [CHAR_W-1:0]                   char_t;
    typedef logic [LENGTH_BITS-1:0]              len_t;
    typedef logic [3:0]                          digit_t;
    typedef logic [DIGITS-1:0][3:0]              bcd_t;
    typedef logic [DIGIT_IDX_W-1:0]              dcnt_t;
    typedef logic [CNT_W-1:0]                    cnt_t;
    typedef logic [MAX_RESULTS-1:0][CHAR_W-1:0]  char_row_t;

    localparam len_t   LEN_MAX_V  = len_t'(LEN_MAX);
    localparam len_t   LEN_SHORT  = len_t'(2);
    localparam digit_t DIGIT_NINE = 4'd9;
    localparam char_t  ASCII_ZERO = 8'h30;

    // one flushed word plus its delimiter, oldest byte in slot 0
    typedef struct packed {
        char_row_t bytes;
        cnt_t      count;
    } rec_t;

    function automatic logic is_delim(input char_t c);
        logic d;
        d = (c == 8'h20) || (c == 8'h0A)
            || (c >= 8'h21 && c <= 8'h2F)
            || (c >= 8'h3A && c <= 8'h40)
            || (c >= 8'h5B && c <= 8'h60)
            || (c >= 8'h7B && c <= 8'h7E);
        return d;
    endfunction

endpackage

// ----- design/wna_word_tracker.sv -----
// input register, word state with decimal length counter, flush record build
`timescale 1ns / 1ps
`include "word_numeronym_abbreviator_defines.svh"

module wna_word_tracker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  wna_pkg::char_t  char_in,
    output logic            rec_valid,
    input  logic            rec_ready,
    output wna_pkg::rec_t   rec
);

    logic            in_valid_reg, in_valid_next;
    wna_pkg::char_t  in_char_reg, in_char_next;
    wna_pkg::len_t   length_reg, length_next;
    wna_pkg::bcd_t   bcd_reg, bcd_next;
    wna_pkg::char_t  first_reg, first_next;
    wna_pkg::char_t  latest_reg, latest_next;

    logic            delim;
    logic            take;
    logic            saturated;
    logic            carry;
    wna_pkg::bcd_t   bcd_inc;
    wna_pkg::dcnt_t  ndig;
    wna_pkg::dcnt_t  didx;

    assign delim     = wna_pkg::is_delim(in_char_reg);
    assign take      = in_valid_reg && (!delim || rec_ready);
    assign in_ready  = !in_valid_reg || take;
    assign rec_valid = in_valid_reg && delim;
    assign saturated = (length_reg == wna_pkg::LEN_MAX_V);

    // decimal increment of length minus two
    always_comb
    begin
        carry = 1'b1;
        for (int i = 0; i < wna_pkg::DIGITS; i++)
        begin
            if (carry && bcd_reg[i] == wna_pkg::DIGIT_NINE)
            begin
                bcd_inc[i] = 4'd0;
            end
            else if (carry)
            begin
                bcd_inc[i] = bcd_reg[i] + 4'd1;
                carry = 1'b0;
            end
            else
            begin
                bcd_inc[i] = bcd_reg[i];
            end
        end
    end

    // significant digit count
    always_comb
    begin
        ndig = '0;
        for (int i = 0; i < wna_pkg::DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                ndig = wna_pkg::dcnt_t'(i + 1);
            end
        end
    end

    // flush record
    always_comb
    begin
        rec.bytes = '0;
        didx = '0;
        if (length_reg == '0)
        begin
            rec.count    = wna_pkg::cnt_t'(1);
            rec.bytes[0] = in_char_reg;
        end
        else if (length_reg == wna_pkg::len_t'(1))
        begin
            rec.count    = wna_pkg::cnt_t'(2);
            rec.bytes[0] = first_reg;
            rec.bytes[1] = in_char_reg;
        end
        else if (length_reg == wna_pkg::LEN_SHORT)
        begin
            rec.count    = wna_pkg::cnt_t'(3);
            rec.bytes[0] = first_reg;
            rec.bytes[1] = latest_reg;
            rec.bytes[2] = in_char_reg;
        end
        else
        begin
            rec.count = wna_pkg::cnt_t'(ndig) + wna_pkg::cnt_t'(3);
            for (int k = 0; k < wna_pkg::MAX_RESULTS; k++)
            begin
                didx = ndig - wna_pkg::dcnt_t'(k);
                if (k == 0)
                begin
                    rec.bytes[k] = first_reg;
                end
                else if (k <= int'(ndig))
                begin
                    rec.bytes[k] = wna_pkg::ASCII_ZERO | {4'd0, bcd_reg[didx]};
                end
                else if (k == int'(ndig) + 1)
                begin
                    rec.bytes[k] = latest_reg;
                end
                else if (k == int'(ndig) + 2)
                begin
                    rec.bytes[k] = in_char_reg;
                end
                else
                begin
                    rec.bytes[k] = '0;
                end
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_char_next  = in_char_reg;
        length_next   = length_reg;
        bcd_next      = bcd_reg;
        first_next    = first_reg;
        latest_next   = latest_reg;

        if (in_ready)
        begin
            in_valid_next = in_valid;
            if (in_valid)
            begin
                in_char_next = char_in;
            end
        end

        if (take && !delim)
        begin
            if (length_reg == '0)
            begin
                first_next = in_char_reg;
            end
            latest_next = in_char_reg;
            if (!saturated)
            begin
                length_next = length_reg + wna_pkg::len_t'(1);
                if (length_reg >= wna_pkg::LEN_SHORT)
                begin
                    bcd_next = bcd_inc;
                end
            end
        end
        else if (take)
        begin
            length_next = '0;
            bcd_next    = '0;
            first_next  = '0;
            latest_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_char_reg  <= '0;
            length_reg   <= '0;
            bcd_reg      <= '0;
            first_reg    <= '0;
            latest_reg   <= '0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            in_char_reg  <= in_char_next;
            length_reg   <= length_next;
            bcd_reg      <= bcd_next;
            first_reg    <= first_next;
            latest_reg   <= latest_next;
        end
    end

    `WNA_ASSERT_ALWAYS(a_len_cap, length_reg <= wna_pkg::LEN_MAX_V, "word length above cap")
    `WNA_ASSERT_SAME(a_bcd_short, length_reg <= wna_pkg::LEN_SHORT, bcd_reg == '0, "digits on short word")
    `WNA_ASSERT_NEXT(a_delim_held, rec_valid && !rec_ready, in_valid_reg && $stable(in_char_reg), "stalled delimiter lost")

endmodule

// ----- design/wna_emitter.sv -----
// record buffer that shifts bytes out through the result register
`timescale 1ns / 1ps
`include "word_numeronym_abbreviator_defines.svh"

module wna_emitter (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            rec_valid,
    output logic            rec_ready,
    input  wna_pkg::rec_t   rec,
    output logic            out_valid,
    input  logic            out_ready,
    output wna_pkg::char_t  char_out,
    output logic            last_of_run
);

    wna_pkg::char_row_t  buf_reg, buf_next;
    wna_pkg::cnt_t       rem_reg, rem_next;
    logic                out_valid_reg, out_valid_next;
    wna_pkg::char_t      char_reg, char_next;
    logic                last_reg, last_next;
    logic                out_load;

    assign out_load  = (rem_reg != '0) && (!out_valid_reg || out_ready);
    assign rec_ready = (rem_reg == '0) || (rem_reg == wna_pkg::cnt_t'(1) && out_load);

    always_comb
    begin
        buf_next       = buf_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        if (out_load)
        begin
            char_next      = buf_reg[0];
            last_next      = (rem_reg == wna_pkg::cnt_t'(1));
            out_valid_next = 1'b1;
            buf_next       = buf_reg >> wna_pkg::CHAR_W;
            rem_next       = rem_reg - wna_pkg::cnt_t'(1);
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (rec_valid && rec_ready)
        begin
            buf_next = rec.bytes;
            rem_next = rec.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            char_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            buf_reg       <= buf_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
            char_reg      <= char_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign char_out    = char_reg;
    assign last_of_run = last_reg;

    `WNA_ASSERT_ALWAYS(a_rem_range, rem_reg <= wna_pkg::cnt_t'(wna_pkg::MAX_RESULTS), "byte count overflow")
    `WNA_ASSERT_SAME(a_run_pending, out_valid_reg && !last_reg, rem_reg != '0, "run cut short")
    `WNA_ASSERT_NEXT(a_final_marked, out_load && rem_reg == wna_pkg::cnt_t'(1), out_valid_reg && last_reg, "final byte unmarked")

endmodule

// ----- design/word_numeronym_abbreviator.sv -----
// top level of the word numeronym abbreviator
//
//   channel   signals                               role
//   input     in_valid, in_ready, char_in           one text byte per request
//   output    out_valid, out_ready, char_out,       one result byte per request,
//             last_of_run                           last_of_run on the delimiter
//
// word bytes are taken one per cycle while no stalled delimiter is ahead of them, and produce nothing
// a delimiter loads 1 to 8 result bytes into the byte serializer, which sends them out one by one
// the first result byte passes through the input register, the record buffer and the result register
// length minus two is kept as a decimal counter, so no conversion step is needed
// asynchronous active-low reset clears the word and drops any pending results
`timescale 1ns / 1ps

module word_numeronym_abbreviator (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  wna_pkg::char_t  char_in,
    output logic            out_valid,
    input  logic            out_ready,
    output wna_pkg::char_t  char_out,
    output logic            last_of_run
);

    logic           rec_valid;
    logic           rec_ready;
    wna_pkg::rec_t  rec;

    wna_word_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_in   (char_in),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec       (rec)
    );

    wna_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec_valid   (rec_valid),
        .rec_ready   (rec_ready),
        .rec         (rec),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_out    (char_out),
        .last_of_run (last_of_run)
    );

endmodule

// ----- tb/numeronym_checker.sv -----
// checker for the word numeronym abbreviator: predicts the output byte stream and compares it
`timescale 1ns / 1ps

module numeronym_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  wna_pkg::char_t  char_in,
    input  logic            out_valid,
    input  logic            out_ready,
    input  wna_pkg::char_t  char_out,
    input  logic            last_of_run,
    output int              fail_count,
    output int              awaited
);

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        wna_pkg::char_t ch;
        logic           last;
    } abbrev_byte_t;

    abbrev_byte_t   abbrev_bytes_q [$];
    wna_pkg::len_t  word_len    = '0;
    wna_pkg::char_t word_first  = '0;
    wna_pkg::char_t word_latest = '0;

    initial
    begin
        fail_count = 0;
        awaited    = 0;
    end

    function automatic bit is_separator(input wna_pkg::char_t c);
        bit hit;
        hit = (c == 8'h0A) || (c == 8'h20);
        hit = hit || (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40);
        hit = hit || (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
        return hit;
    endfunction

    task automatic push_byte(input wna_pkg::char_t c, input logic last);
        abbrev_byte_t b;
        b.ch   = c;
        b.last = last;
        abbrev_bytes_q.push_back(b);
    endtask

    // one request in, zero or more abbreviated bytes expected out
    task automatic abbreviate(input wna_pkg::char_t c);
        int unsigned    rem;
        wna_pkg::char_t digits [$];
        if (!is_separator(c))
        begin
            if (word_len == 0)
                word_first = c;
            word_latest = c;
            if (word_len < wna_pkg::LEN_MAX_V)
                word_len = word_len + 1'b1;
        end
        else
        begin
            if (word_len != 0)
                push_byte(word_first, 1'b0);
            if (word_len == 2)
                push_byte(word_latest, 1'b0);
            else if (word_len > 2)
            begin
                rem = int'(word_len) - 2;
                do
                begin
                    digits.push_front(wna_pkg::char_t'(8'h30 + rem % 10));
                    rem = rem / 10;
                end
                while (rem != 0);
                foreach (digits[i])
                    push_byte(digits[i], 1'b0);
                push_byte(word_latest, 1'b0);
            end
            push_byte(c, 1'b1);
            word_len    = '0;
            word_first  = '0;
            word_latest = '0;
        end
    endtask

    task automatic report(input string msg);
        if (fail_count < PRINT_CAP)
            $display("[%0t] %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        abbrev_byte_t want;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_ready)
            begin
                if (abbrev_bytes_q.size() == 0)
                    report($sformatf("unexpected output byte 0x%0h", char_out));
                else
                begin
                    want = abbrev_bytes_q.pop_front();
                    if (char_out !== want.ch)
                        report($sformatf("char_out 0x%0h, expected 0x%0h", char_out, want.ch));
                    if (last_of_run !== want.last)
                        report($sformatf("last_of_run %b, expected %b on byte 0x%0h",
                                         last_of_run, want.last, want.ch));
                end
            end
            if (in_valid && in_ready === 1'b1)
                abbreviate(char_in);
            awaited <= abbrev_bytes_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// testbench top for the word numeronym abbreviator: stimulus, backpressure and verdict
`timescale 1ns / 1ps

module tb_top;

    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 70;
    localparam int CALM_ITEMS   = 20;
    localparam int DRAIN_CYCLES = 12;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    wna_pkg::char_t char_in   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    wna_pkg::char_t char_out;
    logic           last_of_run;
    int             fail_count;
    int             awaited;

    bit calm         = 1'b0;
    bit hold_req     = 1'b0;
    bit hold_done    = 1'b0;
    int sent_count   = 0;
    int quiet_cycles = 0;

    // field extremes, delimiter range edges and neighboring word bytes
    wna_pkg::char_t directed_bytes [24] = '{
        8'h2C, 8'h00, 8'h20, 8'hFF, 8'h80, 8'h0A, 8'h30, 8'h39,
        8'h41, 8'h21, 8'h5A, 8'h61, 8'h7A, 8'h7F, 8'h2F, 8'h3A,
        8'h1F, 8'h09, 8'h0D, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'h7E
    };

    always #1 clk = ~clk;

    word_numeronym_abbreviator u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_in     (char_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_out    (char_out),
        .last_of_run (last_of_run)
    );

    numeronym_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .char_in     (char_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_out    (char_out),
        .last_of_run (last_of_run),
        .fail_count  (fail_count),
        .awaited     (awaited)
    );

    always @(posedge clk)
    begin
        if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_char(input wna_pkg::char_t c);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        sent_count++;
    endtask

    function automatic wna_pkg::char_t random_word_char();
        wna_pkg::char_t c;
        if ($urandom_range(0, 3) != 0)
            c = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
        else
        begin
            c = 8'($urandom_range(0, 255));
            while (wna_pkg::is_delim(c))
                c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    function automatic wna_pkg::char_t random_separator();
        wna_pkg::char_t c;
        if ($urandom_range(0, 2) == 0)
            c = 8'h20;
        else
        begin
            c = 8'($urandom_range(0, 255));
            while (!wna_pkg::is_delim(c))
                c = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    task automatic send_word(input int len);
        repeat (len) send_char(random_word_char());
    endtask

    initial
    begin
        int len;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_bytes[i])
            send_char(directed_bytes[i]);

        // two digit count
        send_word(13);
        send_char(random_separator());

        hold_req   = 1'b1;
        sent_count = 0;
        while (sent_count < RANDOM_ITEMS)
        begin
            if (sent_count >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            case ($urandom_range(0, 9))
                0: send_char(8'($urandom_range(0, 255)));
                1: send_char(random_separator());
                default:
                begin
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 20)
                                                      : $urandom_range(1, 6);
                    send_word(len);
                    send_char(random_separator());
                end
            endcase
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && awaited == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
